### rtl/utfw_pkg.sv
// Shared types, constants and the wide-character classifier for the UTF-8 width wrapper.
package utfw_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned CW_W    = 2;
  localparam int unsigned COL_W   = 8;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned PEND_W  = 2;

  localparam logic [COL_W-1:0] LINE_WIDTH_RESET = 8'd80;

  // Lead byte thresholds.
  localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;

  // Continuation bytes still expected after each lead kind.
  localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  localparam logic [CW_W-1:0] CW_NARROW = 2'd1;
  localparam logic [CW_W-1:0] CW_WIDE   = 2'd2;

  localparam logic [SUM_W-1:0] SUM_MAX = 16'hFFFF;

  // One result word.
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [CW_W-1:0]  col_span;
    logic             starts_new_line;
    logic [COL_W-1:0] line_column;
    logic [SUM_W-1:0] total_width;
    logic             last;
  } res_t;

  // Display width of a code point: two columns inside the wide ranges.
  function automatic logic [CW_W-1:0] char_cols(input logic [CP_W-1:0] cp);
    logic wide;
    wide = cp inside {[21'h01100:21'h0115F], [21'h02E80:21'h0303E],
                      [21'h03041:21'h033FF], [21'h03400:21'h04DBF],
                      [21'h04E00:21'h09FFF], [21'h0A000:21'h0A4CF],
                      [21'h0AC00:21'h0D7A3], [21'h0F900:21'h0FAFF],
                      [21'h0FE30:21'h0FE6F], [21'h0FF00:21'h0FF60],
                      [21'h0FFE0:21'h0FFE6], [21'h1F300:21'h1FAFF],
                      [21'h20000:21'h3FFFD]};
    return wide ? CW_WIDE : CW_NARROW;
  endfunction

endpackage

### rtl/utf8_display_width_wrapper.sv
// Top level: input register, decode core and output register of the UTF-8 width wrapper.
// An accepted byte goes to the input register, then its word, if any, to the output register.
// Throughput: one byte per cycle unless out_ready stalls; both registers pipeline the core.
// A byte that completes no character and does not end the text produces no word.
// Reset (rst_n low, synchronous) empties both registers, clears the decode and line state
// and sets the line width to 80.
module utf8_display_width_wrapper import utfw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [COL_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_text,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CP_W-1:0]   out_code_point,
  output logic [CW_W-1:0]   out_col_span,
  output logic              out_starts_new_line,
  output logic [COL_W-1:0]  out_line_column,
  output logic [SUM_W-1:0]  out_total_width,
  output logic              out_last
);

  logic [COL_W-1:0]  line_width_r;
  logic              ib_valid_r, ib_valid_nxt;
  logic [BYTE_W-1:0] ib_byte_r;
  logic              ib_eot_r;
  logic              ob_valid_r, ob_valid_nxt;
  res_t              ob_res_r;
  logic              step;
  logic              emit;
  res_t              res;

  // Line width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      line_width_r <= cfg_wr_data;
    end
  end

  // The held word moves through the core once the output register has room.
  assign step         = ib_valid_r & (~ob_valid_r | out_ready);
  assign in_ready     = ~ib_valid_r | step;
  assign ib_valid_nxt = (in_valid & in_ready) | (ib_valid_r & ~step);
  assign ob_valid_nxt = (step & emit) | (ob_valid_r & ~out_ready);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r <= 1'b0;
    end else begin
      ib_valid_r <= ib_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_byte_r <= in_data_byte;
      ib_eot_r  <= in_end_of_text;
    end
  end

  utfw_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (ib_byte_r),
    .end_of_text (ib_eot_r),
    .line_width  (line_width_r),
    .emit        (emit),
    .res         (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
    end else begin
      ob_valid_r <= ob_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      ob_res_r <= res;
    end
  end

  assign out_valid           = ob_valid_r;
  assign out_code_point      = ob_res_r.code_point;
  assign out_col_span        = ob_res_r.col_span;
  assign out_starts_new_line = ob_res_r.starts_new_line;
  assign out_line_column     = ob_res_r.line_column;
  assign out_total_width     = ob_res_r.total_width;
  assign out_last            = ob_res_r.last;

  // A character is always one or two columns wide.
  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_col_span == CW_NARROW || out_col_span == CW_WIDE))
    else $error("column span out of range");

  // After a wrap the line holds only this character.
  a_wrap_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_starts_new_line) |->
      (out_line_column == {{(COL_W-CW_W){1'b0}}, out_col_span}))
    else $error("wrap column mismatch");

  // Without a wrap the column never exceeds the line width.
  a_column_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_starts_new_line) |-> (out_line_column <= line_width_r))
    else $error("line column exceeds line width");

  // The input side stalls only when both registers are full and the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (ib_valid_r && ob_valid_r && !out_ready))
    else $error("input stalled without cause");

endmodule

### rtl/utfw_core.sv
// Decoder and line state: assembles code points and computes wrap, column and total.
module utfw_core import utfw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_text,
  input  logic [COL_W-1:0]  line_width,
  output logic              emit,
  output res_t              res
);

  logic [CP_W-1:0]   point_r, point_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  logic [CP_W-1:0]   cp;
  logic [PEND_W-1:0] pend_dec;
  logic              done;
  logic [CW_W-1:0]   cw;
  logic [COL_W:0]    col_sum;
  logic              wrap;
  logic [COL_W-1:0]  col_new;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_new;

  // Lenient UTF-8 decode of one byte.
  always_comb begin
    cp       = point_r;
    pend_dec = pend_r;
    done     = 1'b0;
    if (pend_r == PEND_NONE) begin
      if (data_byte >= LEAD4_MIN) begin
        cp       = {18'd0, data_byte[2:0]};
        pend_dec = PEND_THREE;
      end else if (data_byte >= LEAD3_MIN) begin
        cp       = {17'd0, data_byte[3:0]};
        pend_dec = PEND_TWO;
      end else if (data_byte >= LEAD2_MIN) begin
        cp       = {16'd0, data_byte[4:0]};
        pend_dec = PEND_ONE;
      end else begin
        cp       = {13'd0, data_byte};
        done     = 1'b1;
      end
    end else begin
      cp       = {point_r[CP_W-7:0], data_byte[5:0]};
      pend_dec = pend_r - PEND_ONE;
      done     = (pend_r == PEND_ONE);
    end
  end

  // Width, wrap test and saturating total.
  always_comb begin
    cw       = char_cols(cp);
    col_sum  = {1'b0, col_r} + {{(COL_W-CW_W+1){1'b0}}, cw};
    wrap     = col_sum > {1'b0, line_width};
    col_new  = wrap ? {{(COL_W-CW_W){1'b0}}, cw} : col_sum[COL_W-1:0];
    sum_wide = {1'b0, sum_r} + {{(SUM_W-CW_W+1){1'b0}}, cw};
    sum_new  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    emit     = done | end_of_text;

    res.code_point      = cp;
    res.col_span        = cw;
    res.starts_new_line = wrap;
    res.line_column     = col_new;
    res.total_width     = sum_new;
    res.last            = end_of_text;
  end

  // Next state: a finished character clears the decoder, end of text clears all.
  always_comb begin
    point_nxt = point_r;
    pend_nxt  = pend_r;
    col_nxt   = col_r;
    sum_nxt   = sum_r;
    if (step) begin
      if (end_of_text) begin
        point_nxt = '0;
        pend_nxt  = PEND_NONE;
        col_nxt   = '0;
        sum_nxt   = '0;
      end else if (done) begin
        point_nxt = '0;
        pend_nxt  = PEND_NONE;
        col_nxt   = col_new;
        sum_nxt   = sum_new;
      end else begin
        point_nxt = cp;
        pend_nxt  = pend_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r <= '0;
      pend_r  <= PEND_NONE;
      col_r   <= '0;
      sum_r   <= '0;
    end else begin
      point_r <= point_nxt;
      pend_r  <= pend_nxt;
      col_r   <= col_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule
